FILE: rtl/lrtf_pkg.sv
package lrtf_pkg;

  localparam int IN_W   = 16;
  localparam int EXT_W  = 32;
  localparam int PN_W   = 5;
  localparam int RES_W  = 21;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 72;

  typedef struct packed {
    logic in_ready;
    logic idx_clr;
    logic scan_rd;
    logic scan_init;
    logic update;
    logic out_load;
    logic idx_inc;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic idx_last;
    logic left_zero;
    logic out_fire;
    logic out_last;
  } sts_t;

endpackage

FILE: rtl/longest_remaining_time_first_scheduler_top.sv
// Longest-remaining-time-first scheduler.
// Slave channel s_axis_*: one process per item, arrival and burst time in
// tdata, tlast on the final process of a set. Loading takes one item per
// cycle; an item beyond MAX_PROCS is dropped, but its tlast still starts the
// run with the processes already held.
// After the last item tready drops and the scheduler runs. Setup scans the
// loaded processes once, then every simulated time unit (or idle jump to the
// next arrival) takes a decision state, a scan of the table through the
// registered read port of the stores, a drain state, then an update. A final
// decision state finds every process done.
// Master channel m_axis_*: one result item per loaded process, in load
// order, tlast on the final one; each result passes a read state and a load
// state before it is offered, since the stores are read at one address per
// cycle. A stalled receiver holds the result and the scheduler with it.
// After the final result is taken, tready rises again for the next set.
// Reset (rst, synchronous) empties the table and the result register; the
// block then waits for the first item.
module longest_remaining_time_first_scheduler_top #(
  parameter int MAX_PROCS  = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // arrival_time[15:0], burst_time[31:16]
  input  logic        s_axis_tlast,  // last_process
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // process_number[4:0], completion_time[25:5], turnaround_time[46:26],
  // waiting_time[67:47], zero fill[71:68]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast   // last_result
);

  lrtf_pkg::cmd_t cmd;
  lrtf_pkg::sts_t sts;

  // Sequence loading, table scans, updates and result delivery.
  lrtf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Hold the process table, simulated time and the result register.
  lrtf_dp #(
    .MAX_PROCS  (MAX_PROCS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Accept items only while loading.
  assign s_axis_tready = cmd.in_ready;

endmodule

FILE: rtl/lrtf_ctrl.sv
module lrtf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  lrtf_pkg::sts_t sts,
  output lrtf_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT_SCAN,
    ST_INIT_DRAIN,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      ST_LOAD: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire && sts.in_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_INIT_SCAN;
        end
      end
      ST_INIT_SCAN: begin
        cmd.scan_rd   = 1'b1;
        cmd.scan_init = 1'b1;
        if (sts.idx_last) begin
          state_next = ST_INIT_DRAIN;
        end
      end
      ST_INIT_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.idx_clr = 1'b1;
        state_next  = sts.left_zero ? ST_OUT_RD : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.idx_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_OUT_RD: begin
        state_next = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (sts.out_fire) begin
          if (sts.out_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/lrtf_dp.sv
module lrtf_dp #(
  parameter int MAX_PROCS  = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lrtf_pkg::cmd_t                  cmd,
  output lrtf_pkg::sts_t                  sts,
  input  logic                            s_axis_tvalid,
  input  logic [lrtf_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lrtf_pkg::M_DATA_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast
);

  localparam int IW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNTW = $clog2(MAX_PROCS + 1);
  localparam int CW   = TIME_WIDTH + CNTW;
  localparam int OW   = (CW > lrtf_pkg::RES_W) ? CW : lrtf_pkg::RES_W;
  localparam int PADW = lrtf_pkg::M_DATA_W - lrtf_pkg::PN_W - 3 * lrtf_pkg::RES_W;

  logic [TIME_WIDTH-1:0] arr_mem  [MAX_PROCS];
  logic [TIME_WIDTH-1:0] bur_mem  [MAX_PROCS];
  logic [TIME_WIDTH-1:0] rem_mem  [MAX_PROCS];
  logic [CW-1:0]         comp_mem [MAX_PROCS];

  logic [TIME_WIDTH-1:0] arr_rd;
  logic [TIME_WIDTH-1:0] bur_rd;
  logic [TIME_WIDTH-1:0] rem_rd;
  logic [CW-1:0]         comp_rd;

  logic [CNTW-1:0]       loaded_count;
  logic [CNTW-1:0]       left;
  logic [MAX_PROCS-1:0]  finished;
  logic [CW-1:0]         cur_time;
  logic [IW-1:0]         idx;
  logic                  d1_valid;
  logic                  d1_init;
  logic [IW-1:0]         d1_idx;

  logic                  found;
  logic [IW-1:0]         best_idx;
  logic [TIME_WIDTH-1:0] best_rem;
  logic [TIME_WIDTH-1:0] best_arr;
  logic                  have_next;
  logic [TIME_WIDTH-1:0] next_arr;

  logic [lrtf_pkg::M_DATA_W-1:0] out_data;
  logic                  out_valid;
  logic                  out_last;

  logic [lrtf_pkg::EXT_W-1:0] arr_in_ext;
  logic [lrtf_pkg::EXT_W-1:0] bur_in_ext;
  logic [TIME_WIDTH-1:0] arr_in;
  logic [TIME_WIDTH-1:0] bur_in;
  logic                  full;
  logic                  in_fire;
  logic                  load_wr;
  logic [IW-1:0]         load_addr;
  logic                  d1_ready;
  logic                  d1_better;
  logic                  upd_done;
  logic [CW-1:0]         time_inc;

  logic [OW-1:0]         c_w;
  logic [OW-1:0]         ta_w;
  logic [OW-1:0]         wt_w;
  logic [IW:0]           pn_wide;

  // Keep the low TIME_WIDTH bits of each incoming time.
  assign arr_in_ext = lrtf_pkg::EXT_W'(s_axis_tdata[lrtf_pkg::IN_W-1:0]);
  assign bur_in_ext = lrtf_pkg::EXT_W'(s_axis_tdata[2*lrtf_pkg::IN_W-1:lrtf_pkg::IN_W]);
  assign arr_in     = arr_in_ext[TIME_WIDTH-1:0];
  assign bur_in     = bur_in_ext[TIME_WIDTH-1:0];

  assign full      = (loaded_count == CNTW'(MAX_PROCS));
  assign in_fire   = s_axis_tvalid && cmd.in_ready;
  assign load_wr   = in_fire && !full;
  assign load_addr = loaded_count[IW-1:0];
  assign time_inc  = cur_time + CW'(1);
  assign upd_done  = found && (best_rem == TIME_WIDTH'(1));

  assign d1_ready  = (CW'(arr_rd) <= cur_time);
  assign d1_better = !found || (rem_rd > best_rem) ||
                     ((rem_rd == best_rem) && (arr_rd < best_arr));

  // Stores: one write port and one registered read port each, read at idx.
  always_ff @(posedge clk) begin
    if (load_wr) begin
      arr_mem[load_addr] <= arr_in;
      bur_mem[load_addr] <= bur_in;
    end
    if (load_wr) begin
      rem_mem[load_addr] <= bur_in;
    end else if (cmd.update && found) begin
      rem_mem[best_idx] <= best_rem - TIME_WIDTH'(1);
    end
    if (d1_valid && d1_init && (rem_rd == '0)) begin
      comp_mem[d1_idx] <= CW'(arr_rd);
    end else if (cmd.update && upd_done) begin
      comp_mem[best_idx] <= time_inc;
    end
    arr_rd  <= arr_mem[idx];
    bur_rd  <= bur_mem[idx];
    rem_rd  <= rem_mem[idx];
    comp_rd <= comp_mem[idx];
  end

  // Scan index and the read pipeline flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      d1_valid <= 1'b0;
    end else begin
      d1_valid <= cmd.scan_rd;
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if ((cmd.scan_rd && !sts.idx_last) || cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    d1_init <= cmd.scan_init;
    d1_idx  <= idx;
  end

  // Table bookkeeping, time and scan accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      left         <= '0;
      finished     <= '0;
      found        <= 1'b0;
      have_next    <= 1'b0;
    end else begin
      if (load_wr) begin
        loaded_count <= loaded_count + CNTW'(1);
      end
      if (cmd.clear) begin
        loaded_count <= '0;
        left         <= '0;
        finished     <= '0;
      end
      if (cmd.idx_clr) begin
        found     <= 1'b0;
        have_next <= 1'b0;
      end
      if (d1_valid && d1_init) begin
        if (rem_rd == '0) begin
          finished[d1_idx] <= 1'b1;
        end else begin
          left <= left + CNTW'(1);
        end
      end
      if (d1_valid && !d1_init && !finished[d1_idx]) begin
        if (d1_ready) begin
          if (d1_better) begin
            found <= 1'b1;
          end
        end else if (!have_next || (arr_rd < next_arr)) begin
          have_next <= 1'b1;
        end
      end
      if (cmd.update && upd_done) begin
        finished[best_idx] <= 1'b1;
        left               <= left - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d1_valid && d1_init) begin
      if ((d1_idx == '0) || (CW'(arr_rd) < cur_time)) begin
        cur_time <= CW'(arr_rd);
      end
    end
    if (d1_valid && !d1_init && !finished[d1_idx]) begin
      if (d1_ready) begin
        if (d1_better) begin
          best_idx <= d1_idx;
          best_rem <= rem_rd;
          best_arr <= arr_rd;
        end
      end else if (!have_next || (arr_rd < next_arr)) begin
        next_arr <= arr_rd;
      end
    end
    if (cmd.update) begin
      cur_time <= found ? time_inc : CW'(next_arr);
    end
  end

  // Result register.
  assign c_w     = OW'(comp_rd);
  assign ta_w    = c_w - OW'(arr_rd);
  assign wt_w    = ta_w - OW'(bur_rd);
  assign pn_wide = {1'b0, idx} + (IW + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {{PADW{1'b0}},
                   wt_w[lrtf_pkg::RES_W-1:0],
                   ta_w[lrtf_pkg::RES_W-1:0],
                   c_w[lrtf_pkg::RES_W-1:0],
                   lrtf_pkg::PN_W'(pn_wide)};
      out_last <= sts.idx_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  assign sts.in_fire   = in_fire;
  assign sts.in_last   = s_axis_tlast;
  assign sts.idx_last  = (CNTW'(idx) == (loaded_count - CNTW'(1)));
  assign sts.left_zero = (left == '0);
  assign sts.out_fire  = out_valid && m_axis_tready;
  assign sts.out_last  = out_last;

endmodule

FILE: rtl/lrtf_checker.sv
module lrtf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Loading and result delivery never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // Final input item starts the run: stop taking items.
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after the final process");

  // Final result taken: back to loading.
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready for a new set after the final result");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind longest_remaining_time_first_scheduler_top lrtf_checker u_lrtf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/tb_top.sv
module tb_top;

  // Table depth and run limit; the single long directed set alone needs about
  // 65535 simulated units.
  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int END_WAIT    = 40;

  // One process as the sender offers it; hold_for_drain makes the sender
  // wait until every expected result has been taken before offering it.
  typedef struct packed {
    logic [lrtf_pkg::IN_W-1:0] arrival;
    logic [lrtf_pkg::IN_W-1:0] burst;
    logic                      last;
    logic                      hold_for_drain;
  } process_item_t;

  // One scheduling result, matching the m_axis_tdata fields.
  typedef struct packed {
    logic [lrtf_pkg::PN_W-1:0]  pnum;
    logic [lrtf_pkg::RES_W-1:0] completion;
    logic [lrtf_pkg::RES_W-1:0] turnaround;
    logic [lrtf_pkg::RES_W-1:0] waiting;
    logic                       last;
  } sched_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [lrtf_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [lrtf_pkg::M_DATA_W-1:0] m_axis_tdata;
  logic                          m_axis_tlast;

  process_item_t process_queue[$];
  sched_result_t sched_results[$];

  // Scheduler mirror: the processes of the set being loaded.
  logic [lrtf_pkg::IN_W-1:0] held_arrival[TABLE_DEPTH];
  logic [lrtf_pkg::IN_W-1:0] held_burst[TABLE_DEPTH];
  int unsigned     held_count = 0;

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  int unsigned rx_stall = 0;
  int unsigned rx_calm = 0;

  longest_remaining_time_first_scheduler_top #(
    .MAX_PROCS (TABLE_DEPTH),
    .TIME_WIDTH(lrtf_pkg::IN_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Run preemptive longest-remaining-time-first over the held set and queue
  // one result per held process, in load order.
  task automatic run_schedule();
    logic [lrtf_pkg::IN_W-1:0] remaining[TABLE_DEPTH];
    bit              finished[TABLE_DEPTH];
    int unsigned     done_at[TABLE_DEPTH];
    int unsigned     now_t;
    int unsigned     next_arrival;
    int unsigned     left;
    int unsigned     sel;
    bit              found;
    bit              have_next;
    sched_result_t   res;

    // Start the clock at the earliest arrival; zero bursts finish on arrival.
    now_t = 32'(held_arrival[0]);
    left  = 0;
    for (int k = 0; k < held_count; k++) begin
      if (held_arrival[k] < now_t) now_t = 32'(held_arrival[k]);
      remaining[k] = held_burst[k];
      finished[k]  = 1'b0;
      done_at[k]   = 0;
      if (held_burst[k] == 0) begin
        finished[k] = 1'b1;
        done_at[k]  = 32'(held_arrival[k]);
      end else begin
        left++;
      end
    end

    while (left > 0) begin
      found        = 1'b0;
      have_next    = 1'b0;
      sel          = 0;
      next_arrival = 0;
      for (int k = 0; k < held_count; k++) begin
        if (finished[k]) continue;
        if (held_arrival[k] <= now_t) begin
          // Longest remaining wins; ties go to earlier arrival, then load order.
          if (!found || remaining[k] > remaining[sel] ||
              (remaining[k] == remaining[sel] &&
               held_arrival[k] < held_arrival[sel])) begin
            sel   = k;
            found = 1'b1;
          end
        end else if (!have_next || held_arrival[k] < next_arrival) begin
          next_arrival = 32'(held_arrival[k]);
          have_next    = 1'b1;
        end
      end
      if (!found) begin
        // Nothing ready: jump to the next arrival.
        now_t = next_arrival;
      end else begin
        remaining[sel]--;
        now_t++;
        if (remaining[sel] == 0) begin
          finished[sel] = 1'b1;
          done_at[sel]  = now_t;
          left--;
        end
      end
    end

    for (int k = 0; k < held_count; k++) begin
      res.pnum       = lrtf_pkg::PN_W'(k + 1);
      res.completion = lrtf_pkg::RES_W'(done_at[k]);
      res.turnaround = lrtf_pkg::RES_W'(done_at[k] - held_arrival[k]);
      res.waiting    = lrtf_pkg::RES_W'(done_at[k] - held_arrival[k] - held_burst[k]);
      res.last       = (k + 1 == held_count);
      sched_results.push_back(res);
    end
    held_count = 0;
  endtask

  // Take one accepted process into the table; drop it when the table is full.
  task automatic absorb_process(input logic [lrtf_pkg::IN_W-1:0] arrival,
                                input logic [lrtf_pkg::IN_W-1:0] burst,
                                input logic last);
    if (held_count < TABLE_DEPTH) begin
      held_arrival[held_count] = arrival;
      held_burst[held_count]   = burst;
      held_count++;
    end
    if (last) run_schedule();
  endtask

  task automatic push_process(input logic [lrtf_pkg::IN_W-1:0] arrival,
                              input logic [lrtf_pkg::IN_W-1:0] burst,
                              input logic last, input logic hold_for_drain);
    process_item_t item;
    item.arrival        = arrival;
    item.burst          = burst;
    item.last           = last;
    item.hold_for_drain = hold_for_drain;
    process_queue.push_back(item);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Sender: hold an offered item until taken, then pick a gap before the next.
  always @(posedge clk) begin : sender
    bit taken;
    taken = 1'b0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken = 1'b1;
        absorb_process(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
        void'(process_queue.pop_front());
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          tx_gap = pick_gap();
          if ($urandom_range(0, 29) == 0) tx_calm = $urandom_range(10, 30);
        end
      end
      if (s_axis_tvalid && !taken) begin
        // Hold the current item until the block takes it.
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (process_queue.size() > 0 &&
                   (!process_queue[0].hold_for_drain || sched_results.size() == 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {process_queue[0].burst, process_queue[0].arrival};
        s_axis_tlast  <= process_queue[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: check each taken result against the oldest expectation, then
  // stall at random; stalls are also thrown in while no result is offered.
  always @(posedge clk) begin : receiver
    sched_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sched_results.size() == 0) begin
          $error("unexpected result item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = sched_results.pop_front();
          check_field("process_number", 32'(want.pnum), 32'(m_axis_tdata[4:0]));
          check_field("completion_time", 32'(want.completion), 32'(m_axis_tdata[25:5]));
          check_field("turnaround_time", 32'(want.turnaround), 32'(m_axis_tdata[46:26]));
          check_field("waiting_time", 32'(want.waiting), 32'(m_axis_tdata[67:47]));
          check_field("last_result", 32'(want.last), 32'(m_axis_tlast));
        end
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_stall = pick_gap();
          if ($urandom_range(0, 29) == 0) rx_calm = $urandom_range(10, 30);
        end
      end else if (!m_axis_tvalid && rx_stall == 0 && rx_calm == 0 &&
                   $urandom_range(0, 19) == 0) begin
        rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if it never drains.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned set_size;
    int unsigned mode;
    int unsigned r;
    logic [lrtf_pkg::IN_W-1:0] base;
    logic [lrtf_pkg::IN_W-1:0] arrival;
    logic [lrtf_pkg::IN_W-1:0] burst;

    // Zero burst alone: completes at its arrival.
    push_process(16'd0, 16'd0, 1'b1, 1'b0);

    // Zero burst among others, a tie on arrival and burst broken by load
    // order, and an idle stretch before the late arrival.
    push_process(16'd7, 16'd0, 1'b0, 1'b1);
    push_process(16'd3, 16'd4, 1'b0, 1'b0);
    push_process(16'd3, 16'd4, 1'b0, 1'b0);
    push_process(16'd10, 16'd2, 1'b0, 1'b0);
    push_process(16'd40, 16'd1, 1'b1, 1'b0);

    // Largest arrival and burst.
    push_process(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);

    // Full table; the extra item is dropped but its last flag starts the run.
    for (int k = 0; k < TABLE_DEPTH; k++)
      push_process(k[15:0], 16'((k * 3) % 7), 1'b0, k == 0);
    push_process(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);

    // Random sets: mostly small bursts so the run stays short; arrivals
    // clustered, tied, or spread over the full range to force idle jumps.
    rand_items = 0;
    while (rand_items < 96) begin
      r = $urandom_range(0, 19);
      if (r == 0) set_size = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 3);
      else if (r < 5) set_size = $urandom_range(9, TABLE_DEPTH);
      else set_size = $urandom_range(1, 8);
      mode = $urandom_range(0, 3);
      base = lrtf_pkg::IN_W'((mode == 3) ? $urandom : $urandom_range(0, 40));
      for (int k = 0; k < set_size; k++) begin
        case (mode)
          0:       arrival = lrtf_pkg::IN_W'(base + $urandom_range(0, 10));
          1:       arrival = base;
          2:       arrival = lrtf_pkg::IN_W'($urandom);
          default: arrival = lrtf_pkg::IN_W'(base + $urandom_range(0, 30));
        endcase
        r = $urandom_range(0, 19);
        if (r == 0) burst = 16'd0;
        else if (r < 17) burst = lrtf_pkg::IN_W'($urandom_range(1, 12));
        else burst = lrtf_pkg::IN_W'($urandom_range(13, 80));
        push_process(arrival, burst, k == set_size - 1,
                     k == 0 && (rand_items == 0 || $urandom_range(0, 3) == 0));
        rand_items++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Wait for the sender to run dry, the results to drain, then settle.
    while (process_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (sched_results.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
